/* rtl/rwfe_pkg.sv */
// Package for the Rabin window feature extractor: sizes, register indexes,
// coefficient tables and the T/U polynomial table functions. No dependencies.
package rwfe_pkg;

  localparam int WindowBytes = 48;
  localparam int MaxFeatures = 12;
  localparam int WinW = $clog2(WindowBytes);
  localparam int FeatW = 4;
  localparam logic [63:0] RabinPoly = 64'hbfe6b8a5bf378d83;
  localparam int Deg = 63;
  localparam int TopShift = Deg - 8;

  localparam logic [0:0] CfgMode = 1'b0;
  localparam logic [0:0] CfgCount = 1'b1;

  typedef logic [63:0] word_t;

  function automatic logic [15:0] coef_a(input logic [3:0] j);
    case (j)
      4'd0: coef_a = 16'd31;   4'd1: coef_a = 16'd53;
      4'd2: coef_a = 16'd23;   4'd3: coef_a = 16'd71;
      4'd4: coef_a = 16'd17;   4'd5: coef_a = 16'd43;
      4'd6: coef_a = 16'd3;    4'd7: coef_a = 16'd19;
      4'd8: coef_a = 16'd79;   4'd9: coef_a = 16'd83;
      4'd10: coef_a = 16'd41;  4'd11: coef_a = 16'd73;
      default: coef_a = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] coef_b(input logic [3:0] j);
    case (j)
      4'd0: coef_b = 16'd6197;   4'd1: coef_b = 16'd17851;
      4'd2: coef_b = 16'd8093;   4'd3: coef_b = 16'd13613;
      4'd4: coef_b = 16'd691;    4'd5: coef_b = 16'd5471;
      4'd6: coef_b = 16'd20369;  4'd7: coef_b = 16'd29717;
      4'd8: coef_b = 16'd18493;  4'd9: coef_b = 16'd2251;
      4'd10: coef_b = 16'd17033; 4'd11: coef_b = 16'd17443;
      default: coef_b = 16'd0;
    endcase
  endfunction

  // x * 2 mod P (degree 63 field)
  function automatic word_t xtime(input word_t v);
    word_t r;
    r = v << 1;
    if (r[Deg]) r = r ^ RabinPoly;
    return r;
  endfunction

  // carry-less 8-bit by field-element product, reduced; elaboration only
  function automatic word_t mulmod8(input logic [7:0] x, input word_t y);
    word_t acc;
    word_t p;
    acc = '0;
    p = y;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) acc = acc ^ p;
      p = xtime(p);
    end
    return acc;
  endfunction

  function automatic word_t t_one();
    return RabinPoly ^ (word_t'(1) << Deg);
  endfunction

  function automatic word_t tab_t(input logic [7:0] j);
    return mulmod8(j, t_one()) | (word_t'(j) << Deg);
  endfunction

  function automatic word_t span_val();
    word_t s;
    s = word_t'(1);
    for (int k = 1; k < WindowBytes; k++) begin
      s = (s << 8) ^ tab_t(s[TopShift +: 8]);
    end
    return s;
  endfunction

  localparam word_t Span = span_val();

  typedef word_t tab_arr_t [256];

  function automatic tab_arr_t build_t();
    tab_arr_t a;
    for (int j = 0; j < 256; j++) a[j] = tab_t(8'(j));
    return a;
  endfunction

  function automatic tab_arr_t build_u();
    tab_arr_t a;
    for (int j = 0; j < 256; j++) a[j] = mulmod8(8'(j), Span);
    return a;
  endfunction

  localparam tab_arr_t TabT = build_t();
  localparam tab_arr_t TabU = build_u();

  typedef struct packed {
    logic       valid;
    logic       last;
    logic       mode;
    logic [3:0] count;
  } step_ctl_t;

endpackage

/* rtl/rabin_window_feature_extractor_unit.sv */
// Rabin window feature extractor top level: config registers and pipeline.
// Uses rwfe_pkg, rwfe_window, rwfe_maxima, rwfe_emit.
// One byte per cycle through a four-stage pipeline (window RAM read,
// fingerprint roll, transform multiply, maxima compare). Features of a chunk
// leave one per cycle while out_stall_i is low, up to 12; if the emitter is
// idle, the first follows the last byte through the stage 1, stage 3,
// snapshot and emitter registers. Bytes flow on while they drain; the pipeline
// holds only if a new chunk ends before the prior chunk's features are taken.
module rabin_window_feature_extractor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  feature_index_o,
  output logic [63:0] feature_value_o,
  output logic        last_feature_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  logic       mode_q;
  logic [3:0] count_q, cnt;
  logic       adv, snap, busy;
  rwfe_pkg::step_ctl_t ctl0, ctl1, snap_ctl;
  rwfe_pkg::word_t fp;
  rwfe_pkg::word_t snap_val [rwfe_pkg::MaxFeatures];

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      count_q <= 4'd12;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rwfe_pkg::CfgMode:  mode_q <= cfg_data_i[0];
        rwfe_pkg::CfgCount: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cnt = (count_q == 4'd0) ? 4'd1 :
               (count_q > 4'(rwfe_pkg::MaxFeatures)) ? 4'(rwfe_pkg::MaxFeatures) : count_q;

  assign adv = !(snap && busy);
  assign in_stall_o = !adv;
  assign ctl0 = '{valid: in_valid_i, last: last_byte_i, mode: mode_q, count: cnt};

  rwfe_window u_win (
    .clk_i, .rst_ni, .adv_i(adv), .in_valid_i, .data_i(data_byte_i),
    .ctl_i(ctl0), .ctl_o(ctl1), .fp_o(fp)
  );

  rwfe_maxima u_max (
    .clk_i, .rst_ni, .adv_i(adv), .ctl_i(ctl1), .fp_i(fp),
    .snap_o(snap), .snap_ctl_o(snap_ctl), .snap_val_o(snap_val)
  );

  rwfe_emit u_emit (
    .clk_i, .rst_ni, .load_i(snap && !busy), .ctl_i(snap_ctl), .val_i(snap_val),
    .busy_o(busy), .out_valid_o, .out_stall_i, .feature_index_o,
    .feature_value_o, .last_feature_o
  );

endmodule

/* rtl/rwfe_window.sv */
// Window byte memory and rolling fingerprint stage. Uses rwfe_pkg.
// Stage 1 reads the dropped byte; stage 2 updates the fingerprint.
module rwfe_window (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   in_valid_i,
  input  logic [7:0]             data_i,
  input  rwfe_pkg::step_ctl_t    ctl_i,
  output rwfe_pkg::step_ctl_t    ctl_o,
  output rwfe_pkg::word_t        fp_o
);

  logic [7:0] mem_q [rwfe_pkg::WindowBytes];
  logic [rwfe_pkg::WindowBytes-1:0] vld_q;
  logic [rwfe_pkg::WinW-1:0] slot_q, slot_d;
  logic [7:0] rd_q, byte_q;
  logic       rvld_q;
  rwfe_pkg::step_ctl_t s1_q;
  rwfe_pkg::word_t fp_q, fp_d, x;
  logic [7:0] old;

  assign slot_d = (slot_q == rwfe_pkg::WinW'(rwfe_pkg::WindowBytes - 1)) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) begin
      mem_q[slot_d] <= data_i;
      rd_q <= mem_q[slot_d];
      byte_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= rwfe_pkg::WinW'(rwfe_pkg::WindowBytes - 1);
      vld_q <= '0;
      s1_q <= '0;
      rvld_q <= 1'b0;
      fp_q <= '0;
    end else if (adv_i) begin
      s1_q <= ctl_i;
      if (in_valid_i) begin
        rvld_q <= vld_q[slot_d];
        if (ctl_i.last) begin
          slot_q <= rwfe_pkg::WinW'(rwfe_pkg::WindowBytes - 1);
          vld_q <= '0;
        end else begin
          slot_q <= slot_d;
          vld_q[slot_d] <= 1'b1;
        end
      end
      if (s1_q.valid) fp_q <= s1_q.last ? '0 : fp_d;
    end
  end

  assign old = rvld_q ? rd_q : 8'd0;
  always_comb begin
    x = fp_q ^ rwfe_pkg::TabU[old];
    fp_d = ((x << 8) | rwfe_pkg::word_t'(byte_q)) ^ rwfe_pkg::TabT[x[rwfe_pkg::TopShift +: 8]];
  end

  assign fp_o  = fp_d;
  assign ctl_o = s1_q;

endmodule

/* rtl/rwfe_maxima.sv */
// Per-slot transform and running maxima of the enabled slots. Uses rwfe_pkg.
// Stage 3 multiplies, stage 4 compares; last byte snapshots maxima to emitter.
module rwfe_maxima (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  rwfe_pkg::step_ctl_t ctl_i,
  input  rwfe_pkg::word_t     fp_i,
  output logic                snap_o,
  output rwfe_pkg::step_ctl_t snap_ctl_o,
  output rwfe_pkg::word_t     snap_val_o [rwfe_pkg::MaxFeatures]
);

  rwfe_pkg::step_ctl_t c3_q;
  rwfe_pkg::word_t     fp3_q;
  rwfe_pkg::word_t     s_q [rwfe_pkg::MaxFeatures];
  rwfe_pkg::word_t     best_q [rwfe_pkg::MaxFeatures];
  rwfe_pkg::word_t     nb [rwfe_pkg::MaxFeatures];

  always_ff @(posedge clk_i) begin
    if (adv_i && ctl_i.valid) begin
      fp3_q <= fp_i;
      for (int j = 0; j < rwfe_pkg::MaxFeatures; j++) begin
        s_q[j] <= fp_i * rwfe_pkg::word_t'(rwfe_pkg::coef_a(4'(j)))
                  + rwfe_pkg::word_t'(rwfe_pkg::coef_b(4'(j)));
      end
    end
  end

  always_comb begin
    for (int j = 0; j < rwfe_pkg::MaxFeatures; j++) begin
      nb[j] = best_q[j];
      if (c3_q.mode) begin
        if (4'(j) < c3_q.count && s_q[j] > best_q[j]) nb[j] = s_q[j];
      end else if (j == 0 && fp3_q > best_q[0]) begin
        nb[j] = fp3_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
      for (int j = 0; j < rwfe_pkg::MaxFeatures; j++) best_q[j] <= '0;
      snap_o <= 1'b0;
      snap_ctl_o <= '0;
    end else if (adv_i) begin
      c3_q <= ctl_i;
      snap_o <= c3_q.valid && c3_q.last;
      snap_ctl_o <= c3_q;
      if (c3_q.valid) begin
        for (int j = 0; j < rwfe_pkg::MaxFeatures; j++) begin
          best_q[j] <= c3_q.last ? '0 : nb[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && c3_q.valid && c3_q.last) begin
      for (int j = 0; j < rwfe_pkg::MaxFeatures; j++) snap_val_o[j] <= nb[j];
    end
  end

endmodule

/* rtl/rwfe_emit.sv */
// Feature emitter: walks a captured set of maxima onto the output channel.
// Uses rwfe_pkg. Busy while emitting; pipeline stalls on a second snapshot.
module rwfe_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  rwfe_pkg::step_ctl_t ctl_i,
  input  rwfe_pkg::word_t     val_i [rwfe_pkg::MaxFeatures],
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          feature_index_o,
  output logic [63:0]         feature_value_o,
  output logic                last_feature_o
);

  rwfe_pkg::word_t vals_q [rwfe_pkg::MaxFeatures];
  logic [3:0] idx_q, n_q;
  logic       act_q;
  logic       fin;

  assign fin = act_q && !out_stall_i && (idx_q + 1'b1 == n_q);
  assign busy_o = act_q && !fin;

  always_ff @(posedge clk_i) begin
    if (load_i) for (int j = 0; j < rwfe_pkg::MaxFeatures; j++) vals_q[j] <= val_i[j];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= '0;
      n_q <= 4'd1;
    end else if (load_i) begin
      act_q <= 1'b1;
      idx_q <= '0;
      n_q <= ctl_i.mode ? ctl_i.count : 4'd1;
    end else if (act_q && !out_stall_i) begin
      idx_q <= idx_q + 1'b1;
      if (fin) act_q <= 1'b0;
    end
  end

  assign out_valid_o = act_q;
  assign feature_index_o = idx_q;
  assign feature_value_o = vals_q[idx_q];
  assign last_feature_o = (idx_q + 1'b1 == n_q);

endmodule
